// ===== hdl/rgba8_pixel_op_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rgba8 pixel op unit assertion macros
// concurrent assertion wrappers used by the top level
// ----------------------------------------------------------------------------
`ifndef RGBA8_PIXEL_OP_UNIT_DEFINES_SVH
`define RGBA8_PIXEL_OP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define RPO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define RPO_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/rpo_pkg.sv =====
// ----------------------------------------------------------------------------
// rpo_pkg
// shared types, constants and helper function of the rgba8 pixel op unit
// ----------------------------------------------------------------------------
package rpo_pkg;

    localparam logic [7:0] CH_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_PREMUL = 2'd0,
        MODE_DEMUL  = 2'd1,
        MODE_OPAQUE = 2'd2,
        MODE_BLEND  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  a_zero;
        logic  a_full;
        logic  sa_zero;
        logic  al_full;
    } ctl_t;

    // one restoring division step: returns {new remainder, quotient bit}
    function automatic logic [8:0] div_step(input logic [7:0] rem,
                                            input logic nb,
                                            input logic [7:0] d);
        logic [8:0] t;
        logic       ge;
        t  = {rem, nb};
        ge = (t >= {1'b0, d});
        if (ge)
        begin
            t = t - {1'b0, d};
        end
        return {t[7:0], ge};
    endfunction

endpackage

// ===== hdl/rpo_lane.sv =====
// ----------------------------------------------------------------------------
// rpo_lane
// one color channel: multiply, two-stage restoring divide and result select
// ----------------------------------------------------------------------------
module rpo_lane
(
    input  logic           clk,
    input  logic           en,
    input  rpo_pkg::ctl_t  ctl1,
    input  logic [7:0]     dst_c,
    input  logic [7:0]     src_c,
    input  logic [7:0]     da,
    input  logic [7:0]     al,
    input  rpo_pkg::ctl_t  ctl2,
    output logic [7:0]     result
);

    logic [15:0] prod_reg;
    logic [15:0] prod_next;
    logic [7:0]  rem_reg;
    logic [7:0]  rem_next;
    logic [3:0]  qhi_reg;
    logic [3:0]  qhi_next;
    logic [3:0]  nlo_reg;
    logic [7:0]  a_reg;
    logic [7:0]  c_reg;
    logic [7:0]  s_reg;
    logic        ge_reg;

    logic [15:0] numer;
    logic [17:0] sprod;
    logic [8:0]  mx;
    logic [8:0]  my;
    logic [8:0]  st;
    logic [8:0]  st_lo;
    logic [7:0]  rem_lo;
    logic [3:0]  qlo;
    logic [15:0] prem_sum;

    // stage one: shared multiplier and upper half of the divide
    always_comb
    begin
        if (ctl1.mode == rpo_pkg::MODE_BLEND)
        begin
            mx = {1'b0, src_c} - {1'b0, dst_c};
            my = {1'b0, al};
        end
        else
        begin
            mx = {1'b0, dst_c};
            my = {1'b0, da};
        end
        sprod = $signed(mx) * $signed(my);
        if (ctl1.mode == rpo_pkg::MODE_BLEND)
        begin
            sprod = sprod + {2'b00, dst_c, 8'h00};
        end
        prod_next = sprod[15:0];

        numer    = {dst_c, 8'h00} - {8'h00, dst_c};
        rem_next = numer[15:8];
        for (int i = 0; i < 4; i++)
        begin
            st          = rpo_pkg::div_step(rem_next, numer[7 - i], da);
            rem_next    = st[8:1];
            qhi_next[3 - i] = st[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            rem_reg  <= rem_next;
            qhi_reg  <= qhi_next;
            nlo_reg  <= numer[3:0];
            a_reg    <= da;
            c_reg    <= dst_c;
            s_reg    <= src_c;
            ge_reg   <= (dst_c >= da);
        end
    end

    // stage two: lower half of the divide and selection
    always_comb
    begin
        rem_lo = rem_reg;
        for (int i = 0; i < 4; i++)
        begin
            st_lo      = rpo_pkg::div_step(rem_lo, nlo_reg[3 - i], a_reg);
            rem_lo     = st_lo[8:1];
            qlo[3 - i] = st_lo[0];
        end
        prem_sum = prod_reg + 16'(rpo_pkg::CH_MAX);

        case (ctl2.mode)
            rpo_pkg::MODE_PREMUL:
            begin
                if (ctl2.a_full)
                    result = c_reg;
                else if (ctl2.a_zero)
                    result = 8'h00;
                else
                    result = prem_sum[15:8];
            end
            rpo_pkg::MODE_DEMUL:
            begin
                if (ctl2.a_full)
                    result = c_reg;
                else if (ctl2.a_zero)
                    result = 8'h00;
                else if (ge_reg)
                    result = rpo_pkg::CH_MAX;
                else
                    result = {qhi_reg, qlo};
            end
            rpo_pkg::MODE_BLEND:
            begin
                if (ctl2.sa_zero)
                    result = c_reg;
                else if (ctl2.al_full)
                    result = s_reg;
                else
                    result = prod_reg[15:8];
            end
            default:
            begin
                result = c_reg;
            end
        endcase
    end

endmodule

// ===== hdl/rpo_merge.sv =====
// ----------------------------------------------------------------------------
// rpo_merge
// alpha channel and output register combining the color lanes
// ----------------------------------------------------------------------------
module rpo_merge
(
    input  logic           clk,
    input  logic           en,
    input  logic [7:0]     da,
    input  logic [7:0]     al,
    input  rpo_pkg::ctl_t  ctl2,
    input  logic [7:0]     red_c,
    input  logic [7:0]     green_c,
    input  logic [7:0]     blue_c,
    output logic [7:0]     out_red,
    output logic [7:0]     out_green,
    output logic [7:0]     out_blue,
    output logic [7:0]     out_alpha
);

    logic [15:0] aprod_reg;
    logic [7:0]  da_reg;
    logic [7:0]  al_reg;
    logic [15:0] asum;
    logic [7:0]  alpha_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aprod_reg <= al * da;
            da_reg    <= da;
            al_reg    <= al;
        end
    end

    always_comb
    begin
        asum = aprod_reg + 16'(rpo_pkg::CH_MAX);
        case (ctl2.mode)
            rpo_pkg::MODE_OPAQUE:
            begin
                alpha_next = rpo_pkg::CH_MAX;
            end
            rpo_pkg::MODE_BLEND:
            begin
                if (ctl2.sa_zero)
                    alpha_next = da_reg;
                else if (ctl2.al_full)
                    alpha_next = rpo_pkg::CH_MAX;
                else
                    alpha_next = al_reg + da_reg - asum[15:8];
            end
            default:
            begin
                alpha_next = da_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            alpha_reg <= alpha_next;
        end
    end

    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;

endmodule

// ===== hdl/rgba8_pixel_op_unit.sv =====
// ----------------------------------------------------------------------------
// rgba8_pixel_op_unit
// per-pixel rgba8 premultiply, demultiply, opaque and source-over blend
// ----------------------------------------------------------------------------
// input channel in_valid / in_stall carries one pixel item: mode, destination
// pixel, source color, source alpha and coverage
// output channel out_valid / out_stall returns the new destination pixel
// out_valid rises as the item reaches the output register; one item per cycle
// unless out_stall freezes the pipeline: an input register with the coverage
// multiply, then three color lanes and an alpha path, each lane with one
// multiplier and a four-step divide slice per stage, then the output register
// reset clears the valid bits of all stages; payload is not reset
// when out_stall holds off a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; it drops as soon as the result is taken
// ----------------------------------------------------------------------------
`include "rgba8_pixel_op_unit_defines.svh"

module rgba8_pixel_op_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] dst_red,
    input  logic [7:0] dst_green,
    input  logic [7:0] dst_blue,
    input  logic [7:0] dst_alpha,
    input  logic [7:0] src_red,
    input  logic [7:0] src_green,
    input  logic [7:0] src_blue,
    input  logic [7:0] src_alpha,
    input  logic [7:0] coverage,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    logic           en;
    logic           v1_reg;
    logic           v2_reg;
    logic           out_valid_reg;
    rpo_pkg::mode_t mode_reg;
    logic [7:0]     dr_reg;
    logic [7:0]     dg_reg;
    logic [7:0]     db_reg;
    logic [7:0]     da_reg;
    logic [7:0]     sr_reg;
    logic [7:0]     sg_reg;
    logic [7:0]     sb_reg;
    logic           sa_zero_reg;
    logic [7:0]     al_reg;
    logic [7:0]     al_next;
    logic [15:0]    cov_prod;
    rpo_pkg::ctl_t  ctl1;
    rpo_pkg::ctl_t  ctl2_reg;
    logic [7:0]     red_c;
    logic [7:0]     green_c;
    logic [7:0]     blue_c;
    logic           opaque_adv;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        cov_prod = src_alpha * {1'b0, coverage} + {8'h00, src_alpha};
        if (coverage == rpo_pkg::CH_MAX)
            al_next = src_alpha;
        else
            al_next = cov_prod[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg    <= rpo_pkg::mode_t'(mode);
            dr_reg      <= dst_red;
            dg_reg      <= dst_green;
            db_reg      <= dst_blue;
            da_reg      <= dst_alpha;
            sr_reg      <= src_red;
            sg_reg      <= src_green;
            sb_reg      <= src_blue;
            sa_zero_reg <= (src_alpha == 8'h00);
            al_reg      <= al_next;
            ctl2_reg    <= ctl1;
        end
    end

    always_comb
    begin
        ctl1.mode    = mode_reg;
        ctl1.a_zero  = (da_reg == 8'h00);
        ctl1.a_full  = (da_reg == rpo_pkg::CH_MAX);
        ctl1.sa_zero = sa_zero_reg;
        ctl1.al_full = (al_reg == rpo_pkg::CH_MAX);
    end

    rpo_lane u_lane_red
    (
        .clk    (clk),
        .en     (en),
        .ctl1   (ctl1),
        .dst_c  (dr_reg),
        .src_c  (sr_reg),
        .da     (da_reg),
        .al     (al_reg),
        .ctl2   (ctl2_reg),
        .result (red_c)
    );

    rpo_lane u_lane_green
    (
        .clk    (clk),
        .en     (en),
        .ctl1   (ctl1),
        .dst_c  (dg_reg),
        .src_c  (sg_reg),
        .da     (da_reg),
        .al     (al_reg),
        .ctl2   (ctl2_reg),
        .result (green_c)
    );

    rpo_lane u_lane_blue
    (
        .clk    (clk),
        .en     (en),
        .ctl1   (ctl1),
        .dst_c  (db_reg),
        .src_c  (sb_reg),
        .da     (da_reg),
        .al     (al_reg),
        .ctl2   (ctl2_reg),
        .result (blue_c)
    );

    rpo_merge u_merge
    (
        .clk       (clk),
        .en        (en),
        .da        (da_reg),
        .al        (al_reg),
        .ctl2      (ctl2_reg),
        .red_c     (red_c),
        .green_c   (green_c),
        .blue_c    (blue_c),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    assign out_valid = out_valid_reg;

    assign opaque_adv = v2_reg && en && (ctl2_reg.mode == rpo_pkg::MODE_OPAQUE);

    // pipeline advance and opaque alpha
    `RPO_ASSERT_NEXT(a_stage_advance, clk, rst_n, v1_reg && en, v2_reg)
    `RPO_ASSERT_NEXT(a_opaque_alpha, clk, rst_n, opaque_adv, out_alpha == rpo_pkg::CH_MAX)
    `RPO_ASSERT_NEXT(a_result_follows, clk, rst_n, v2_reg && en, out_valid)

endmodule
